// File: src/cfws_pkg.sv
`timescale 1ns / 1ps

package cfws_pkg;

  // default sizing
  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_DATA_WIDTH = 32;
  localparam int CAP_DEFAULT        = 64;

  // fixed field widths
  localparam int REQ_W = 3;
  localparam int CAP_W = 7;
  localparam int POS_W = 6;
  localparam int OCC_W = 7;
  localparam int ST_W  = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE = 3'd0,
    REQ_DEQUEUE = 3'd1,
    REQ_PEEK    = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_SEARCH  = 3'd4
  } req_code_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_SEARCH
  } seq_state_t;

  // configuration handed from the register to the sequencer
  typedef struct packed {
    logic             clear;
    logic [CAP_W-1:0] cap;
  } cfg_t;

endpackage

// File: src/cfws_req_if.sv
`timescale 1ns / 1ps

interface cfws_req_if #(
  parameter int DATA_WIDTH = cfws_pkg::DEFAULT_DATA_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic [cfws_pkg::REQ_W-1:0]    req_type;
  logic signed [DATA_WIDTH-1:0]  value;

  modport source (output valid, input ready, output req_type, output value);
  modport sink   (input valid, output ready, input req_type, input value);
endinterface

// File: src/cfws_rsp_if.sv
`timescale 1ns / 1ps

interface cfws_rsp_if #(
  parameter int DATA_WIDTH = cfws_pkg::DEFAULT_DATA_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  read_value;
  logic [cfws_pkg::POS_W-1:0]    found_position;
  logic [cfws_pkg::OCC_W-1:0]    occupancy;
  logic [cfws_pkg::ST_W-1:0]     status;

  modport source (output valid, input ready, output read_value, output found_position,
                  output occupancy, output status);
  modport sink   (input valid, output ready, input read_value, input found_position,
                  input occupancy, input status);
endinterface

// File: src/circular_fifo_with_search_core.sv
`timescale 1ns / 1ps

// Circular FIFO of signed words with a front-to-back search. Each request
// transaction (enqueue, dequeue, peek, clear, search) yields exactly one
// response transaction carrying the word read, the match position, the
// occupancy after the operation and a status. Enqueue, clear, rejections,
// search on an empty queue and unused request codes answer from the idle
// state; dequeue and peek go through the fetch state, as the storage memory
// has a registered read port; search of a non-empty queue stays in the
// search state while it compares entries up to and including the first
// match (all occupied entries if none matches, so at most DEPTH), as the
// single read port and comparator visit one entry per cycle. A new request
// is taken once the sequencer is idle and the response register is empty
// or being drained. The storage needs no clearing after reset. Writing the
// capacity register also empties the queue at the same clock edge.
module circular_fifo_with_search_core #(
  parameter int DEPTH      = cfws_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = cfws_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cfws_pkg::CAP_W-1:0]   cfg_wdata,
  cfws_req_if.sink                     req,
  cfws_rsp_if.source                   rsp
);

  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CAP_RESET = (DEPTH < cfws_pkg::CAP_DEFAULT) ? DEPTH : cfws_pkg::CAP_DEFAULT;

  logic [cfws_pkg::CAP_W-1:0] cap, cap_next;
  cfws_pkg::cfg_t             cfg;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // capacity clamp: zero reads as one, above the store size reads as its size
  always_comb begin
    cap_next = cap;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_next = cfws_pkg::CAP_W'(1);
      end else if (32'(cfg_wdata) > DEPTH) begin
        cap_next = cfws_pkg::CAP_W'(DEPTH);
      end else begin
        cap_next = cfg_wdata;
      end
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= cfws_pkg::CAP_W'(CAP_RESET);
    end else begin
      cap <= cap_next;
    end
  end

  // a capacity write empties the queue at the same edge
  assign cfg.clear = cfg_we;
  assign cfg.cap   = cap;

  cfws_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cfws_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // capacity always within one and the store size
  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    cap != '0 && 32'(cap) <= DEPTH)
    else $error("capacity out of range");

  // no new request while an undelivered response is held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !(rsp.valid && !rsp.ready))
    else $error("request accepted over a pending response");

  // an empty rejection reports an empty queue
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == cfws_pkg::ST_EMPTY) |-> rsp.occupancy == '0)
    else $error("empty status with non-zero occupancy");

endmodule

// File: src/cfws_ram.sv
`timescale 1ns / 1ps

module cfws_ram #(
  parameter int DEPTH      = cfws_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = cfws_pkg::DEFAULT_DATA_WIDTH,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/cfws_seq.sv
`timescale 1ns / 1ps

module cfws_seq #(
  parameter int DEPTH      = cfws_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = cfws_pkg::DEFAULT_DATA_WIDTH,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfws_pkg::cfg_t        cfg,
  cfws_req_if.sink              req,
  cfws_rsp_if.source            rsp,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic [IDX_W-1:0]      mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int OCC_W = cfws_pkg::OCC_W;
  localparam int POS_W = cfws_pkg::POS_W;
  localparam int CMP_W = ((IDX_W > cfws_pkg::CAP_W) ? IDX_W : cfws_pkg::CAP_W) + 1;

  cfws_pkg::seq_state_t state, state_next;

  logic [IDX_W-1:0]      head, head_next;
  logic [IDX_W-1:0]      tail, tail_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [OCC_W-1:0]      count, count_next;
  logic [OCC_W-1:0]      pos_cnt, pos_cnt_next;
  logic [cfws_pkg::REQ_W-1:0] op, op_next;
  logic [DATA_WIDTH-1:0] key, key_next;

  logic                  rsp_valid, rsp_valid_next;
  logic [DATA_WIDTH-1:0] rsp_read_value, rsp_read_value_next;
  logic [POS_W-1:0]      rsp_pos, rsp_pos_next;
  logic [OCC_W-1:0]      rsp_occ, rsp_occ_next;
  cfws_pkg::status_t     rsp_status, rsp_status_next;

  logic accept;

  // index step with wrap at the capacity in use
  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                           input logic [cfws_pkg::CAP_W-1:0] c);
    logic [CMP_W-1:0] nx;
    nx = CMP_W'(i) + CMP_W'(1);
    if (nx >= CMP_W'(c) || nx >= CMP_W'(DEPTH)) begin
      return '0;
    end
    return nx[IDX_W-1:0];
  endfunction

  assign req.ready          = (state == cfws_pkg::SEQ_IDLE) && (!rsp_valid || rsp.ready);
  assign accept             = req.valid && req.ready;
  assign rsp.valid          = rsp_valid;
  assign rsp.read_value     = rsp_read_value;
  assign rsp.found_position = rsp_pos;
  assign rsp.occupancy      = rsp_occ;
  assign rsp.status         = rsp_status;

  assign mem_waddr = tail;
  assign mem_wdata = req.value;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfws_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    idx            <= idx_next;
    pos_cnt        <= pos_cnt_next;
    op             <= op_next;
    key            <= key_next;
    rsp_read_value <= rsp_read_value_next;
    rsp_pos        <= rsp_pos_next;
    rsp_occ        <= rsp_occ_next;
    rsp_status     <= rsp_status_next;
  end

  // sequencer: next state, index updates, shared compare unit and result load
  always_comb begin
    state_next          = state;
    head_next           = head;
    tail_next           = tail;
    idx_next            = idx;
    count_next          = count;
    pos_cnt_next        = pos_cnt;
    op_next             = op;
    key_next            = key;
    rsp_valid_next      = rsp_valid && !rsp.ready;
    rsp_read_value_next = rsp_read_value;
    rsp_pos_next        = rsp_pos;
    rsp_occ_next        = rsp_occ;
    rsp_status_next     = rsp_status;
    mem_we              = 1'b0;
    mem_raddr           = head;

    unique case (state)
      cfws_pkg::SEQ_IDLE: begin
        if (accept) begin
          op_next             = req.req_type;
          key_next            = req.value;
          rsp_read_value_next = '0;
          rsp_pos_next        = '0;
          rsp_status_next     = cfws_pkg::ST_OK;
          rsp_occ_next        = count;
          rsp_valid_next      = 1'b1;
          unique case (req.req_type)
            cfws_pkg::REQ_ENQUEUE: begin
              if (count >= cfg.cap) begin
                rsp_status_next = cfws_pkg::ST_FULL;
              end else begin
                mem_we       = 1'b1;
                tail_next    = adv(tail, cfg.cap);
                count_next   = count + OCC_W'(1);
                rsp_occ_next = count + OCC_W'(1);
              end
            end
            cfws_pkg::REQ_DEQUEUE, cfws_pkg::REQ_PEEK: begin
              if (count == '0) begin
                rsp_status_next = cfws_pkg::ST_EMPTY;
              end else begin
                // wait for the registered read of the front entry
                rsp_valid_next = 1'b0;
                state_next     = cfws_pkg::SEQ_FETCH;
              end
            end
            cfws_pkg::REQ_CLEAR: begin
              head_next    = '0;
              tail_next    = '0;
              count_next   = '0;
              rsp_occ_next = '0;
            end
            cfws_pkg::REQ_SEARCH: begin
              if (count == '0) begin
                rsp_status_next = cfws_pkg::ST_NOT_FOUND;
              end else begin
                rsp_valid_next = 1'b0;
                idx_next       = adv(head, cfg.cap);
                pos_cnt_next   = '0;
                state_next     = cfws_pkg::SEQ_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cfws_pkg::SEQ_FETCH: begin
        rsp_read_value_next = mem_rdata;
        rsp_pos_next        = '0;
        rsp_status_next     = cfws_pkg::ST_OK;
        rsp_occ_next        = count;
        rsp_valid_next      = 1'b1;
        if (op == cfws_pkg::REQ_DEQUEUE) begin
          head_next    = adv(head, cfg.cap);
          count_next   = count - OCC_W'(1);
          rsp_occ_next = count - OCC_W'(1);
        end
        state_next = cfws_pkg::SEQ_IDLE;
      end

      cfws_pkg::SEQ_SEARCH: begin
        // one stored entry compared per cycle, next read issued alongside
        mem_raddr           = idx;
        rsp_read_value_next = '0;
        rsp_occ_next        = count;
        if (mem_rdata == key) begin
          rsp_pos_next    = pos_cnt[POS_W-1:0];
          rsp_status_next = cfws_pkg::ST_OK;
          rsp_valid_next  = 1'b1;
          state_next      = cfws_pkg::SEQ_IDLE;
        end else if (pos_cnt + OCC_W'(1) == count) begin
          rsp_pos_next    = '0;
          rsp_status_next = cfws_pkg::ST_NOT_FOUND;
          rsp_valid_next  = 1'b1;
          state_next      = cfws_pkg::SEQ_IDLE;
        end else begin
          idx_next     = adv(idx, cfg.cap);
          pos_cnt_next = pos_cnt + OCC_W'(1);
        end
      end

      default: begin
        state_next = cfws_pkg::SEQ_IDLE;
      end
    endcase

    // capacity write empties the queue
    if (cfg.clear) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end
  end

endmodule
